### hdl/x86ild_pkg.sv
// shared constants and decode helpers for the x86 instruction length decoder
package x86ild_pkg;

  // window geometry
  localparam int unsigned WindowBytes = 16;
  localparam int unsigned WindowW     = WindowBytes * 8;
  localparam int unsigned IdxW        = $clog2(WindowBytes);
  localparam int unsigned CountW      = 5;
  localparam int unsigned LenW        = 5;
  localparam int unsigned ClsW        = 6;
  localparam int unsigned SumW        = 6;
  localparam int unsigned InTdataW    = 136;
  localparam int unsigned OutTdataW   = 16;

  // operation class codes
  localparam logic [ClsW-1:0] ClsUnk  = 6'd0;
  localparam logic [ClsW-1:0] ClsMov  = 6'd1;
  localparam logic [ClsW-1:0] ClsLea  = 6'd2;
  localparam logic [ClsW-1:0] ClsAlu  = 6'd3;
  localparam logic [ClsW-1:0] ClsShf  = 6'd11;
  localparam logic [ClsW-1:0] ClsGrp3 = 6'd19;
  localparam logic [ClsW-1:0] ClsGrp5 = 6'd27;
  localparam logic [ClsW-1:0] ClsMax  = 6'd34;

  // opcode bytes with a meaning of their own
  localparam logic [7:0] OpEscape  = 8'h0F;
  localparam logic [7:0] OpOpsize  = 8'h66;

  // skipped prefix: segment, lock, fwait, rep/repne, 0x64..0x67
  function automatic logic is_prefix(input logic [7:0] b);
    is_prefix = ((b & 8'hE7) == 8'h26) || ((b & 8'hFC) == 8'h64) ||
                (b == 8'h9B) || (b == 8'hF0) || ((b & 8'hFE) == 8'hF2);
  endfunction

  // byte of the window at a given index
  function automatic logic [7:0] get_byte(input logic [WindowW-1:0] win,
                                          input logic [IdxW-1:0] idx);
    get_byte = win[idx*8 +: 8];
  endfunction

endpackage

### hdl/x86_instruction_length_decode.sv
// x86 instruction length decoder: input register, single-pass decode, result register
// a request passes the input register, the combinational decode and then the result register
// throughput: one request per cycle while the result is not stalled; the decode has no state carried between requests
// a stalled result lets one more request into the input register, then tready drops
// reset: asynchronous active-low rst_ni clears both stage valid flags, payload is not reset
module x86_instruction_length_decode (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // bytes_low [63:0], bytes_high [127:64], valid_count [132:128], zero [135:133]
  input  logic [x86ild_pkg::InTdataW-1:0]    s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // length [4:0], op_class [10:5], zero [15:11]
  output logic [x86ild_pkg::OutTdataW-1:0]   m_axis_tdata_o
);
  import x86ild_pkg::*;

  logic                  in_vld_q;
  logic [WindowW-1:0]    win_q;
  logic [CountW-1:0]     cnt_q;
  logic                  out_vld_q;
  logic [LenW-1:0]       out_len_q;
  logic [ClsW-1:0]       out_cls_q;
  logic                  out_adv;
  logic                  in_adv;
  logic [LenW-1:0]       out_len_d;
  logic [ClsW-1:0]       out_cls_d;

  // stage handshake
  assign out_adv         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign in_adv          = !in_vld_q || out_adv;
  assign s_axis_tready_o = in_adv;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutTdataW-LenW-ClsW){1'b0}}, out_cls_q, out_len_q};

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_adv) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid_i) begin
      win_q <= s_axis_tdata_i[WindowW-1:0];
      cnt_q <= s_axis_tdata_i[WindowW +: CountW];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      out_len_q <= out_len_d;
      out_cls_q <= out_cls_d;
    end
  end

  // prefix scan: first non-prefix byte and operand size parity
  logic [WindowBytes-1:0] pfx;
  logic [CountW-1:0]      p;
  logic                   opsz_par;

  always_comb begin
    p        = CountW'(WindowBytes);
    opsz_par = 1'b0;
    for (int i = 0; i < WindowBytes; i++) begin
      pfx[i] = is_prefix(get_byte(win_q, IdxW'(i))) ||
               (get_byte(win_q, IdxW'(i)) == OpOpsize);
    end
    for (int i = WindowBytes - 1; i >= 0; i--) begin
      if (!pfx[i]) begin
        p = CountW'(i);
      end
    end
    for (int i = 0; i < WindowBytes; i++) begin
      if ((CountW'(i) < p) && (get_byte(win_q, IdxW'(i)) == OpOpsize)) begin
        opsz_par = ~opsz_par;
      end
    end
  end

  // opcode, modrm, sib and immediate decode
  logic [CountW-1:0] n;
  logic [SumW-1:0]   w;
  logic [7:0]        c;
  logic [7:0]        c2;
  logic [7:0]        modrm;
  logic [7:0]        sib;
  logic [CountW-1:0] p1;
  logic [CountW-1:0] q;
  logic [CountW-1:0] q1;
  logic [SumW-1:0]   plen;
  logic [SumW-1:0]   base;
  logic [SumW-1:0]   mlen;
  logic [SumW-1:0]   tl;
  logic [SumW-1:0]   res_len;
  logic [ClsW-1:0]   res_cls;
  logic [ClsW-1:0]   cls_b;
  logic [ClsW-1:0]   cls_m;
  logic [ClsW-1:0]   rmop;
  logic              mr_go;
  logic              grp3;
  logic              has_sib;

  always_comb begin
    n       = (cnt_q > CountW'(WindowBytes)) ? CountW'(WindowBytes) : cnt_q;
    w       = opsz_par ? SumW'(2) : SumW'(4);
    plen    = SumW'(p) + SumW'(1);
    p1      = p + CountW'(1);
    c       = get_byte(win_q, p[IdxW-1:0]);
    c2      = get_byte(win_q, p1[IdxW-1:0]);
    res_len = plen;
    res_cls = ClsUnk;
    mr_go   = 1'b0;
    q       = p1;
    base    = plen;
    rmop    = ClsUnk;
    cls_b   = ClsUnk;
    grp3    = 1'b0;
    modrm   = 8'h00;
    sib     = 8'h00;
    q1      = '0;
    mlen    = '0;
    tl      = '0;
    cls_m   = ClsUnk;
    has_sib = 1'b0;

    if (p >= n) begin
      // window holds only prefixes
      res_len = SumW'(n) + SumW'(1);
    end else if (c == OpEscape) begin
      // two-byte opcodes
      if (p1 >= n) begin
        res_len = plen;
      end else begin
        base = plen + SumW'(1);
        q    = p + CountW'(2);
        priority if ((c2 & 8'hF0) == 8'h80) begin
          res_len = base + w;
        end else if (((c2 & 8'hF8) == 8'hC8) || ((c2 & 8'hF8) == 8'h30) ||
                     (c2 >= 8'h06 && c2 <= 8'h0D) ||
                     (c2 >= 8'hA0 && c2 <= 8'hA2) ||
                     (c2 >= 8'hA8 && c2 <= 8'hAA)) begin
          res_len = base;
        end else begin
          mr_go = 1'b1;
          if ((c2 == 8'hBA) || ((c2 & 8'hF7) == 8'hA4)) begin
            base = base + SumW'(1);
          end
        end
      end
    end else begin
      // one-byte opcodes
      cls_b = (c[7:6] == 2'b00) ? ClsAlu + ClsW'(c[5:3]) : ClsUnk;
      priority if (((c & 8'hFE) == 8'hE8) || ((c & 8'hF8) == 8'hB8)) begin
        res_len = plen + w;
      end else if ((c == 8'h9A) || (c == 8'hEA)) begin
        res_len = plen + w + SumW'(2);
      end else if (c == 8'hC8) begin
        res_len = plen + SumW'(3);
      end else if ((c & 8'hC6) == 8'h06) begin
        res_len = plen;
      end else if (((c & 8'hC6) == 8'h04) || ((c & 8'hFE) == 8'hA8)) begin
        res_len = plen + (c[0] ? w : SumW'(1));
        res_cls = cls_b;
      end else if ((c & 8'hFC) == 8'hA0) begin
        res_len = plen + SumW'(4);
        res_cls = ClsMov;
      end else if ((c >= 8'h40 && c <= 8'h61) || (c >= 8'h6C && c <= 8'h6F) ||
                   (c >= 8'hEC && c <= 8'hF5) || (c >= 8'hF8 && c <= 8'hFD) ||
                   (c >= 8'h90 && c <= 8'hAF) || ((c & 8'hF7) == 8'hC3) ||
                   (c == 8'hC9) || (c == 8'hCC) || ((c & 8'hFE) == 8'hCE) ||
                   ((c & 8'hFE) == 8'hD6)) begin
        res_len = plen;
        res_cls = cls_b;
      end else if ((c & 8'hFD) == 8'h68) begin
        res_len = plen + (c[1] ? SumW'(1) : w);
      end else if (((c & 8'hF0) == 8'h70) || ((c & 8'hF8) == 8'hE0) ||
                   ((c & 8'hFE) == 8'hD4) || (c == 8'hCD) || (c == 8'hEB) ||
                   ((c & 8'hF8) == 8'hB0)) begin
        res_len = plen + SumW'(1);
      end else if ((c & 8'hF7) == 8'hC2) begin
        res_len = plen + SumW'(2);
      end else begin
        // opcode followed by modrm
        mr_go = 1'b1;
        if ((c & 8'hFC) == 8'h80) begin
          base = base + ((c[1:0] == 2'b01) ? w : SumW'(1));
          rmop = ClsAlu;
        end
        if (((c & 8'hFE) == 8'hC0) || (c == 8'h6B) || (c == 8'hC6)) begin
          base = base + SumW'(1);
        end
        if ((c == 8'h69) || (c == 8'hC7)) begin
          base = base + w;
        end
        if ((c & 8'hFC) == 8'hD0) begin
          rmop = ClsShf;
        end
        if ((c & 8'hFE) == 8'hF6) begin
          rmop = ClsGrp3;
          grp3 = 1'b1;
        end
        if ((c & 8'hFE) == 8'hFE) begin
          rmop = ClsGrp5;
        end
        if ((c & 8'hFC) == 8'h88) begin
          cls_b = ClsMov;
        end
        if (c == 8'h8D) begin
          cls_b = ClsLea;
        end
      end
    end

    // modrm, sib and displacement
    if (mr_go) begin
      if (q >= n) begin
        res_len = base;
        res_cls = cls_b;
      end else begin
        modrm   = get_byte(win_q, q[IdxW-1:0]);
        q1      = q + CountW'(1);
        sib     = get_byte(win_q, q1[IdxW-1:0]);
        mlen    = base + SumW'(1);
        cls_m   = (rmop != ClsUnk) ? rmop + ClsW'(modrm[5:3]) : cls_b;
        has_sib = (modrm[2:0] == 3'd4) && (modrm[7:6] != 2'b11);
        res_cls = cls_m;
        if (has_sib && (q1 >= n)) begin
          res_len = mlen;
        end else begin
          tl = mlen;
          if (has_sib) begin
            tl = tl + SumW'(1);
            if ((modrm[7:6] == 2'b00) && (sib[2:0] == 3'd5)) begin
              tl = tl + SumW'(4);
            end
          end
          if ((modrm & 8'hC7) == 8'h05) begin
            tl = tl + SumW'(4);
          end
          if (grp3 && (modrm[5:4] == 2'b00)) begin
            tl = tl + (c[0] ? w : SumW'(1));
          end
          unique case (modrm[7:6])
            2'b01:   tl = tl + SumW'(1);
            2'b10:   tl = tl + SumW'(4);
            default: tl = tl;
          endcase
          res_len = tl;
        end
      end
    end

    out_len_d = res_len[LenW-1:0];
    out_cls_d = res_cls;
  end

  // checks
  ap_len_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_len_q != '0))
    else $error("zero length result");

  ap_cls_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_cls_q <= ClsMax))
    else $error("operation class out of range");

  ap_empty_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && (cnt_q == '0)) |-> ((out_len_d == LenW'(1)) && (out_cls_d == ClsUnk)))
    else $error("empty window must give length one");

  ap_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_adv |=> out_vld_q)
    else $error("decoded request lost");

  ap_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_vld_q && out_vld_q && !m_axis_tready_i))
    else $error("input stalled without back-pressure");

endmodule

### sim/tb.sv
// testbench for the x86 instruction length decoder: streamed windows checked against a predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import x86ild_pkg::*;

  localparam int unsigned ClkHalf     = 4;
  localparam int unsigned ResetCycles = 9;
  localparam int unsigned RandomItems = 1350;
  localparam int unsigned PhaseLen    = 150;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned HoldStart   = 610;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned ShownFaults = 10;

  // idling pattern, chosen from the number of requests taken so far
  typedef enum int unsigned {
    PhaseFree,
    PhaseSendIdle,
    PhaseRecvStall,
    PhaseBoth
  } idle_phase_e;

  // one decoded instruction as it leaves the block
  typedef struct packed {
    logic [LenW-1:0] length;
    logic [ClsW-1:0] op_class;
  } decode_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_tvalid = 1'b0;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_tdata  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata_o;

  // windows waiting to be offered, and decodes waiting to come out
  logic [InTdataW-1:0] window_queue[$];
  decode_t             due_decodes[$];

  int unsigned in_count    = 0;
  int unsigned quiet_count = 0;
  int unsigned hold_left   = 0;
  bit          hold_done   = 1'b0;
  int unsigned fault_count = 0;
  decode_t     want;
  decode_t     got;

  // opcodes that take a ModRM byte, so that the tail decode gets exercised
  logic [7:0] modrm_ops [20] = '{
    8'h00, 8'h03, 8'h80, 8'h81, 8'h82, 8'h83, 8'h88, 8'h8B, 8'h8D, 8'hC6,
    8'hC7, 8'hF6, 8'hF7, 8'hFE, 8'hFF, 8'hD0, 8'hD3, 8'h69, 8'h6B, 8'hC1
  };

  // prefixes the decoder skips over
  logic [7:0] prefix_pool [12] = '{
    8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65,
    8'h66, 8'h67, 8'h9B, 8'hF0, 8'hF2, 8'hF3
  };

  x86_instruction_length_decode uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #ClkHalf clk_i = ~clk_i;

  function automatic idle_phase_e phase_of(input int unsigned taken);
    return idle_phase_e'((taken / PhaseLen) % 4);
  endfunction

  function automatic decode_t make_decode(input int unsigned len, input int unsigned cls);
    decode_t r;
    r.length   = len[LenW-1:0];
    r.op_class = cls[ClsW-1:0];
    return r;
  endfunction

  // length and class of the instruction at the start of a window
  function automatic decode_t predict_decode(input logic [WindowW-1:0] win,
                                             input logic [CountW-1:0] count);
    int unsigned n, pos, len, imm, rmop, cls;
    logic [7:0]  c, modrm, sib;
    bit          o32;
    n    = (count > WindowBytes) ? WindowBytes : count;
    pos  = 0;
    len  = 1;
    rmop = 0;
    cls  = ClsUnk;
    o32  = 1'b1;
    c    = 8'h00;

    // prefix run, each operand size prefix flips the immediate width
    forever begin
      if (pos >= n) return make_decode(len, cls);
      c = win[pos*8 +: 8];
      pos++;
      if (c == OpOpsize) begin
        o32 = !o32;
      end else if ((c & 8'hE7) != 8'h26 && (c & 8'hFC) != 8'h64 && c != 8'h9B &&
                   c != 8'hF0 && (c & 8'hFE) != 8'hF2) begin
        break;
      end
      len++;
    end
    imm = o32 ? 4 : 2;

    if (c == OpEscape) begin
      // two-byte map, class always unknown
      if (pos >= n) return make_decode(len, cls);
      c = win[pos*8 +: 8];
      pos++;
      len++;
      if ((c & 8'hF0) == 8'h80) return make_decode(len + imm, cls);
      if ((c & 8'hF8) == 8'hC8 || (c & 8'hF8) == 8'h30 || (c >= 8'h06 && c <= 8'h0D) ||
          (c >= 8'hA0 && c <= 8'hA2) || (c >= 8'hA8 && c <= 8'hAA))
        return make_decode(len, cls);
      if (c == 8'hBA || (c & 8'hF7) == 8'hA4) len++;
      c = OpEscape;
    end else begin
      // one-byte map: forms that end without a ModRM byte
      if ((c & 8'hFE) == 8'hE8 || (c & 8'hF8) == 8'hB8) return make_decode(len + imm, cls);
      if (c == 8'h9A || c == 8'hEA) return make_decode(len + imm + 2, cls);
      if (c == 8'hC8) return make_decode(len + 3, cls);
      if ((c & 8'hC6) == 8'h06) return make_decode(len, cls);
      if (c < 8'h40) cls = ClsAlu + (c >> 3);
      if ((c & 8'hC6) == 8'h04 || (c & 8'hFE) == 8'hA8)
        return make_decode(len + (c[0] ? imm : 1), cls);
      if ((c & 8'hFC) == 8'hA0) return make_decode(len + 4, ClsMov);
      if ((c >= 8'h40 && c <= 8'h61) || (c >= 8'h6C && c <= 8'h6F) ||
          (c >= 8'hEC && c <= 8'hF5) || (c >= 8'hF8 && c <= 8'hFD) ||
          (c >= 8'h90 && c <= 8'hAF) || (c & 8'hF7) == 8'hC3 || c == 8'hC9 ||
          c == 8'hCC || (c & 8'hFE) == 8'hCE || (c & 8'hFE) == 8'hD6)
        return make_decode(len, cls);
      if ((c & 8'hFD) == 8'h68) return make_decode(len + (c[1] ? 1 : imm), cls);
      if ((c & 8'hF0) == 8'h70 || (c & 8'hF8) == 8'hE0 || (c & 8'hFE) == 8'hD4 ||
          c == 8'hCD || c == 8'hEB || (c & 8'hF8) == 8'hB0)
        return make_decode(len + 1, cls);
      if ((c & 8'hF7) == 8'hC2) return make_decode(len + 2, cls);

      // forms with a ModRM byte: immediates and group selection
      if ((c & 8'hFC) == 8'h80) begin
        len += (c[1:0] == 2'd1) ? imm : 1;
        rmop = ClsAlu;
      end
      if ((c & 8'hFE) == 8'hC0 || c == 8'h6B || c == 8'hC6) len++;
      if (c == 8'h69 || c == 8'hC7) len += imm;
      if ((c & 8'hFC) == 8'hD0) rmop = ClsShf;
      if ((c & 8'hFE) == 8'hF6) rmop = ClsGrp3;
      if ((c & 8'hFE) == 8'hFE) rmop = ClsGrp5;
      if ((c & 8'hFC) == 8'h88) cls = ClsMov;
      if (c == 8'h8D) cls = ClsLea;
    end

    // ModRM, optional SIB, displacement, group 3 test immediate
    if (pos >= n) return make_decode(len, cls);
    modrm = win[pos*8 +: 8];
    pos++;
    if (rmop != 0) cls = rmop + modrm[5:3];
    len++;
    if (modrm[2:0] == 3'd4 && modrm[7:6] != 2'b11) begin
      if (pos >= n) return make_decode(len, cls);
      sib = win[pos*8 +: 8];
      len++;
      if (modrm[7:6] == 2'b00 && sib[2:0] == 3'd5) len += 4;
    end
    if ((modrm & 8'hC7) == 8'h05) len += 4;
    if ((c & 8'hFE) == 8'hF6 && modrm[5:4] == 2'b00) len += c[0] ? imm : 1;
    if (modrm[7:6] == 2'b01) len += 1;
    else if (modrm[7:6] == 2'b10) len += 4;
    return make_decode(len, cls);
  endfunction

  // queue one request: leading bytes as given, the rest of the window random
  task automatic add_code(input logic [7:0] lead[$], input int unsigned count);
    logic [WindowW-1:0] win;
    for (int w = 0; w < WindowW / 32; w++) win[w*32 +: 32] = $urandom();
    for (int j = 0; j < lead.size() && j < WindowBytes; j++) win[j*8 +: 8] = lead[j];
    window_queue.push_back(InTdataW'({count[CountW-1:0], win}));
  endtask

  task automatic add_fill(input logic [7:0] b, input int unsigned count);
    logic [7:0] lead[$];
    for (int j = 0; j < WindowBytes; j++) lead.push_back(b);
    add_code(lead, count);
  endtask

  task automatic report_fault(input string what, input decode_t exp_d, input decode_t got_d);
    if (fault_count < ShownFaults)
      $display("%s: expected length %0d class %0d, got length %0d class %0d",
               what, exp_d.length, exp_d.op_class, got_d.length, got_d.op_class);
    fault_count++;
  endtask

  // sender: offers the next window once the previous one has gone, idling at random in some phases
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_tvalid || s_axis_tready_o) begin
        if (window_queue.size() != 0 &&
            !(phase_of(in_count) == PhaseSendIdle && $urandom_range(0, 99) < 62) &&
            !(phase_of(in_count) == PhaseBoth && $urandom_range(0, 99) < 11)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= window_queue.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls per phase, plus one long hold-off to back the block up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_count >= HoldStart) begin
      m_tready  <= 1'b0;
      hold_left <= HoldCycles - 1;
      hold_done <= 1'b1;
    end else begin
      m_tready <= !((phase_of(in_count) == PhaseRecvStall && $urandom_range(0, 99) < 62) ||
                    (phase_of(in_count) == PhaseBoth && $urandom_range(0, 99) < 11));
    end
  end

  // monitor: predicts on every request taken, checks every result taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready_o) begin
        due_decodes.push_back(predict_decode(s_tdata[WindowW-1:0],
                                             s_tdata[WindowW +: CountW]));
        in_count <= in_count + 1;
      end
      if (m_axis_tvalid_o && m_tready) begin
        got.length   = m_axis_tdata_o[LenW-1:0];
        got.op_class = m_axis_tdata_o[LenW +: ClsW];
        if (due_decodes.size() == 0) begin
          report_fault("result with nothing outstanding", '0, got);
        end else begin
          want = due_decodes.pop_front();
          if (got.length !== want.length || got.op_class !== want.op_class)
            report_fault("decode mismatch", want, got);
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
        quiet_count <= 0;
      end else if (quiet_count >= QuietLimit) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_count <= quiet_count + 1;
      end
    end
  end

  initial begin
    logic [7:0]  lead[$];
    int unsigned k;
    int unsigned pick;
    int unsigned count;

    // directed: empty window, uniform windows, clamped count, long prefix runs
    lead = {};
    add_code(lead, 0);
    add_fill(8'h00, 16);
    add_fill(8'hFF, 16);
    add_fill(8'hFF, 31);
    add_fill(8'h26, 16);
    add_fill(8'h66, 17);
    // operand size toggling
    lead = {8'h66, 8'h05};
    add_code(lead, 16);
    lead = {8'h66, 8'h66, 8'h05};
    add_code(lead, 16);
    // two-byte map: near jcc, shift-double with immediate, escape cut short
    lead = {8'h0F, 8'h80};
    add_code(lead, 16);
    lead = {8'h0F, 8'hA4, 8'hC1};
    add_code(lead, 16);
    lead = {OpEscape};
    add_code(lead, 1);
    // alu group with SIB and disp32 base, then a register-form alu op
    lead = {8'h80, 8'h3C, 8'h25};
    add_code(lead, 16);
    lead = {8'h01, 8'hC0};
    add_code(lead, 16);
    // group 3 test with immediates
    lead = {8'hF6, 8'h05};
    add_code(lead, 16);
    lead = {8'h66, 8'hF7, 8'hC0};
    add_code(lead, 16);
    // group 5, shift group, lea, mov forms
    lead = {8'hFF, 8'h50};
    add_code(lead, 16);
    lead = {8'hD3, 8'hE8};
    add_code(lead, 16);
    lead = {8'h8D, 8'h05};
    add_code(lead, 16);
    lead = {8'hA1};
    add_code(lead, 16);
    // far call, enter, shift by immediate (class unknown), push of segment
    lead = {8'h9A};
    add_code(lead, 16);
    lead = {8'hC8};
    add_code(lead, 16);
    lead = {8'hC0, 8'hE0};
    add_code(lead, 16);
    lead = {8'h06};
    add_code(lead, 16);
    // address size prefix leaves ModRM decoding as it is
    lead = {8'h67, 8'h8B, 8'h06};
    add_code(lead, 16);
    // running out of bytes before ModRM and before SIB, then prefixed imul with SIB and disp32
    lead = {8'h8B};
    add_code(lead, 1);
    lead = {8'h8B, 8'h04};
    add_code(lead, 2);
    lead = {8'hF0, 8'hF3, 8'h2E, 8'h69, 8'h84, 8'h24};
    add_code(lead, 16);

    // random: prefix runs, ModRM-heavy opcodes, two-byte map, raw noise
    for (int i = 0; i < RandomItems; i++) begin
      lead = {};
      pick = $urandom_range(0, 99);
      k = (pick < 60) ? 0 : (pick < 85) ? $urandom_range(1, 2) :
          (pick < 95) ? $urandom_range(3, 5) : $urandom_range(6, 16);
      for (int j = 0; j < k; j++) lead.push_back(prefix_pool[$urandom_range(0, 11)]);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        lead.push_back(modrm_ops[$urandom_range(0, 19)]);
      end else if (pick < 7) begin
        lead.push_back(OpEscape);
      end
      pick = $urandom_range(0, 99);
      count = (pick < 65) ? WindowBytes : (pick < 90) ? $urandom_range(0, 16) :
              $urandom_range(17, 31);
      add_code(lead, count);
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the last request and its result, then let the pipeline drain
    do @(negedge clk_i);
    while (window_queue.size() != 0 || s_tvalid || due_decodes.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);

    if (fault_count == 0 && due_decodes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
hdl/x86ild_pkg.sv
hdl/x86_instruction_length_decode.sv
sim/tb.sv
